FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WMO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define WMO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/wmo_pkg.sv
package wmo_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_CHANNELS      = 2'd0;
  localparam logic [1:0] CFG_SAMPLES_PER_POINT = 2'd1;
  localparam logic [1:0] CFG_NUM_POINTS        = 2'd2;

  // Fixed field widths
  localparam int unsigned NCH_W = 4;
  localparam int unsigned SPP_W = 32;
  localparam int unsigned IDX_W = 20;

  // Reset values of the configuration registers
  localparam logic [NCH_W-1:0] NCH_RESET = 4'd2;
  localparam logic [SPP_W-1:0] SPP_RESET = 32'd1;
  localparam logic [IDX_W-1:0] NPTS_RESET = 20'd1024;

  // Bucket settings seen by the tracker
  typedef struct packed {
    logic [SPP_W-1:0] spp;
    logic [IDX_W-1:0] npts;
  } trk_cfg_t;

  // Update request from the sequencer to the tracker
  typedef struct packed {
    logic fire;
    logic last;
  } upd_ctl_t;

endpackage

FILE: rtl/waveform_min_max_overview.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: chan0..chan7 samples, tlast: last frame
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: index, min, max, tlast: final bucket
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each frame passes in order through lane capture, channel sum, reciprocal
// multiply, quotient correction and bucket update.
// The next frame is taken in the cycle after the update.
// Reset clears the configuration to its defaults and the track state to zero.
// One result waits in the output register; the update step holds only while
// that register is full and not being taken.
module waveform_min_max_overview #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // chan0_sample .. chan7_sample, SAMPLE_BITS each, from bit 0 up
  input  logic [((8*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // bucket_index (20), bucket_min (SAMPLE_BITS), bucket_max (SAMPLE_BITS-1), zero fill
  output logic [((wmo_pkg::IDX_W+2*SAMPLE_BITS-1+7)/8)*8-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int unsigned IDX_W  = wmo_pkg::IDX_W;
  localparam int unsigned NCH_W  = wmo_pkg::NCH_W;
  localparam int unsigned OUT_W  = ((IDX_W + 2*SAMPLE_BITS - 1 + 7) / 8) * 8;
  localparam int unsigned USED_W = IDX_W + 2*SAMPLE_BITS - 1;

  // Sequencer steps
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SUM  = 3'd1;
  localparam logic [2:0] PH_MUL  = 3'd2;
  localparam logic [2:0] PH_FIX  = 3'd3;
  localparam logic [2:0] PH_UPD  = 3'd4;

  logic [2:0]               phase_q, phase_d;
  logic [NCH_W-1:0]         nch_q;
  logic [wmo_pkg::SPP_W-1:0] spp_q;
  logic [IDX_W-1:0]         npts_q;
  logic [NCH_W-1:0]         eff_nch;
  logic [NCH_W-1:0]         item_nch_q;
  logic                     last_q;
  logic                     accept;
  logic                     upd_ready;

  logic signed [SAMPLE_BITS-1:0] lanes [MAX_CHANNELS];
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] avg;

  wmo_pkg::upd_ctl_t ctl;
  wmo_pkg::trk_cfg_t tcfg;

  logic [IDX_W-1:0]              bucket_index;
  logic signed [SAMPLE_BITS-1:0] bucket_min;
  logic [SAMPLE_BITS-2:0]        bucket_max;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (phase_q == PH_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nch_q  <= wmo_pkg::NCH_RESET;
      spp_q  <= wmo_pkg::SPP_RESET;
      npts_q <= wmo_pkg::NPTS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wmo_pkg::CFG_NUM_CHANNELS:      nch_q  <= cfg_data_i[NCH_W-1:0];
        wmo_pkg::CFG_SAMPLES_PER_POINT: spp_q  <= cfg_data_i;
        wmo_pkg::CFG_NUM_POINTS:        npts_q <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the channel count to one through MAX_CHANNELS
  always_comb begin
    if (nch_q == '0) begin
      eff_nch = NCH_W'(1);
    end else if (nch_q > NCH_W'(MAX_CHANNELS)) begin
      eff_nch = NCH_W'(MAX_CHANNELS);
    end else begin
      eff_nch = nch_q;
    end
  end

  // Step through one frame at a time
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: if (accept) phase_d = PH_SUM;
      PH_SUM:  phase_d = PH_MUL;
      PH_MUL:  phase_d = PH_FIX;
      PH_FIX:  phase_d = PH_UPD;
      PH_UPD:  if (upd_ready) phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Hold the frame's side information
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_nch_q <= eff_nch;
      last_q     <= s_axis_tlast;
    end
  end

  // One lane per channel
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    wmo_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .ld_i    (accept),
      .en_i    (NCH_W'(c) < eff_nch),
      .sample_i(s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
      .lane_o  (lanes[c])
    );
  end

  wmo_merge #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .ld_i   (phase_q == PH_SUM),
    .lanes_i(lanes),
    .sum_o  (sum)
  );

  wmo_div #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .mul_en_i(phase_q == PH_MUL),
    .fix_en_i(phase_q == PH_FIX),
    .sum_i   (sum),
    .nch_i   (item_nch_q),
    .avg_o   (avg)
  );

  assign ctl.fire  = (phase_q == PH_UPD);
  assign ctl.last  = last_q;
  assign tcfg.spp  = spp_q;
  assign tcfg.npts = npts_q;

  wmo_track #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cfg_i         (tcfg),
    .avg_i         (avg),
    .ready_o       (upd_ready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .bucket_index_o(bucket_index),
    .bucket_min_o  (bucket_min),
    .bucket_max_o  (bucket_max),
    .final_bucket_o(m_axis_tlast)
  );

  // Pack the result item, zero filled to whole bytes
  assign m_axis_tdata = OUT_W'({bucket_max, bucket_min, bucket_index});

  if (OUT_W < USED_W) begin : g_bad_width
    $error("output packing too narrow");
  end

endmodule

FILE: rtl/wmo_lane.sv
module wmo_lane #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] lane_o
);

  logic signed [SAMPLE_BITS-1:0] lane_q;

  // Capture the channel sample, or zero when the channel is not active
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      lane_q <= en_i ? sample_i : '0;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: rtl/wmo_merge.sv
module wmo_merge #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic signed [SAMPLE_BITS-1:0] lanes_i [MAX_CHANNELS],
  output logic signed [SAMPLE_BITS+$clog2(MAX_CHANNELS)-1:0] sum_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(MAX_CHANNELS);

  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] sum_q;

  // Add up the lane values with sign extension
  always_comb begin
    sum_d = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      sum_d = sum_d + SUM_W'(lanes_i[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/wmo_div.sv
module wmo_div #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          mul_en_i,
  input  logic                          fix_en_i,
  input  logic signed [SAMPLE_BITS+$clog2(MAX_CHANNELS)-1:0] sum_i,
  input  logic [wmo_pkg::NCH_W-1:0]     nch_i,
  output logic signed [SAMPLE_BITS-1:0] avg_o
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  localparam int unsigned REM_W  = SUM_W + wmo_pkg::NCH_W;

  // Reciprocals floor(2^SUM_W / n); the estimate is at most one below the quotient
  localparam logic [64:0] POW = 65'd1 << SUM_W;
  localparam logic [RCP_W-1:0] RCP1 = RCP_W'(POW / 65'd1);
  localparam logic [RCP_W-1:0] RCP2 = RCP_W'(POW / 65'd2);
  localparam logic [RCP_W-1:0] RCP3 = RCP_W'(POW / 65'd3);
  localparam logic [RCP_W-1:0] RCP4 = RCP_W'(POW / 65'd4);
  localparam logic [RCP_W-1:0] RCP5 = RCP_W'(POW / 65'd5);
  localparam logic [RCP_W-1:0] RCP6 = RCP_W'(POW / 65'd6);
  localparam logic [RCP_W-1:0] RCP7 = RCP_W'(POW / 65'd7);
  localparam logic [RCP_W-1:0] RCP8 = RCP_W'(POW / 65'd8);

  logic [RCP_W-1:0]          rcp;
  logic [SUM_W-1:0]          mag;
  logic [PROD_W-1:0]         prod_q;
  logic [SUM_W-1:0]          mag_q;
  logic                      neg_q;
  logic [wmo_pkg::NCH_W-1:0] n_q;
  logic [SUM_W-1:0]          q_est;
  logic [REM_W-1:0]          rem;
  logic [SUM_W-1:0]          quo;
  logic [SAMPLE_BITS-1:0]    quo_s;
  logic signed [SAMPLE_BITS-1:0] avg_q;

  // Pick the reciprocal for the channel count
  always_comb begin
    case (nch_i)
      4'd1:    rcp = RCP1;
      4'd2:    rcp = RCP2;
      4'd3:    rcp = RCP3;
      4'd4:    rcp = RCP4;
      4'd5:    rcp = RCP5;
      4'd6:    rcp = RCP6;
      4'd7:    rcp = RCP7;
      4'd8:    rcp = RCP8;
      default: rcp = RCP1;
    endcase
  end

  // Magnitude of the sum; the most negative sum maps onto its unsigned value
  assign mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

  // Multiply step
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= PROD_W'(mag) * PROD_W'(rcp);
      mag_q  <= mag;
      neg_q  <= sum_i[SUM_W-1];
      n_q    <= nch_i;
    end
  end

  // Correction step: bump the estimate when the remainder reaches the divisor
  assign q_est = prod_q[2*SUM_W-1:SUM_W];
  assign rem   = REM_W'(mag_q) - (REM_W'(q_est) * REM_W'(n_q));
  assign quo   = (rem >= REM_W'(n_q)) ? q_est + SUM_W'(1) : q_est;
  assign quo_s = quo[SAMPLE_BITS-1:0];

  // Restore the sign, which truncates toward zero
  always_ff @(posedge clk_i) begin
    if (fix_en_i) begin
      avg_q <= neg_q ? -quo_s : quo_s;
    end
  end

  assign avg_o = avg_q;

endmodule

FILE: rtl/wmo_track.sv
module wmo_track #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wmo_pkg::upd_ctl_t             ctl_i,
  input  wmo_pkg::trk_cfg_t             cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] avg_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wmo_pkg::IDX_W-1:0]     bucket_index_o,
  output logic signed [SAMPLE_BITS-1:0] bucket_min_o,
  output logic [SAMPLE_BITS-2:0]        bucket_max_o,
  output logic                          final_bucket_o
);

  localparam int unsigned IDX_W = wmo_pkg::IDX_W;
  localparam int unsigned SPP_W = wmo_pkg::SPP_W;

  logic [SPP_W-1:0]              frames_q, frames_d;
  logic [IDX_W-1:0]              buckets_q, buckets_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic                          out_valid_q, out_valid_d;
  logic [IDX_W-1:0]              idx_q;
  logic signed [SAMPLE_BITS-1:0] omin_q;
  logic [SAMPLE_BITS-2:0]        omax_q;
  logic                          fin_q;

  logic                          go;
  logic                          full;
  logic                          close;
  logic                          fin;
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] new_min;
  logic signed [SAMPLE_BITS-1:0] new_max;
  logic [SPP_W:0]                frames_inc;

  // The output register takes a new item when empty or being drained
  assign ready_o = !out_valid_q || out_ready_i;
  assign go      = ctl_i.fire && ready_o;

  assign full       = buckets_q >= cfg_i.npts;
  assign new_min    = (avg_i < min_q) ? avg_i : min_q;
  assign new_max    = (avg_i > max_q) ? avg_i : max_q;
  assign frames_inc = {1'b0, frames_q} + (SPP_W+1)'(1);
  // A zero bucket size closes on every frame, same as a size of one
  assign close      = ctl_i.last || (frames_inc >= {1'b0, cfg_i.spp});
  assign fin        = ctl_i.last || ((buckets_q + IDX_W'(1)) == cfg_i.npts);
  assign emit       = go && !full && close;

  // Advance the bucket state
  always_comb begin
    frames_d  = frames_q;
    buckets_d = buckets_q;
    min_d     = min_q;
    max_d     = max_q;
    if (go) begin
      if (full) begin
        if (ctl_i.last) begin
          frames_d  = '0;
          buckets_d = '0;
          min_d     = '0;
          max_d     = '0;
        end
      end else if (!close) begin
        frames_d = frames_inc[SPP_W-1:0];
        min_d    = new_min;
        max_d    = new_max;
      end else begin
        frames_d  = '0;
        min_d     = '0;
        max_d     = '0;
        buckets_d = ctl_i.last ? '0 : buckets_q + IDX_W'(1);
      end
    end
  end

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= '0;
      buckets_q   <= '0;
      min_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      frames_q    <= frames_d;
      buckets_q   <= buckets_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result item
  always_ff @(posedge clk_i) begin
    if (emit) begin
      idx_q  <= buckets_q;
      omin_q <= new_min;
      omax_q <= new_max[SAMPLE_BITS-2:0];
      fin_q  <= fin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = idx_q;
  assign bucket_min_o   = omin_q;
  assign bucket_max_o   = omax_q;
  assign final_bucket_o = fin_q;

endmodule

FILE: rtl/wmo_checker.sv
`include "assert_macros.svh"

module wmo_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [((wmo_pkg::IDX_W+2*SAMPLE_BITS-1+7)/8)*8-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  logic signed [SAMPLE_BITS-1:0] out_min;
  logic                          in_acc;

  assign out_min = m_axis_tdata[wmo_pkg::IDX_W +: SAMPLE_BITS];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // Once a frame is accepted the block is busy and stops taking input
  `WMO_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready)

  // A new result comes only out of the busy update step
  `WMO_ASSERT(a_result_from_update, clk_i, rst_ni,
              $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

  // The bucket minimum starts at zero and can only fall
  `WMO_ASSERT(a_min_nonpositive, clk_i, rst_ni,
              m_axis_tvalid |-> (out_min[SAMPLE_BITS-1] || out_min == '0))

  // A stalled result stays put
  `WMO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind waveform_min_max_overview wmo_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wmo_checker (.*);

FILE: dv/testbench.sv
module testbench;

  localparam int unsigned IDX_W = wmo_pkg::IDX_W;
  localparam int unsigned SMP_W = 24;
  localparam int unsigned NCH_MAX = 8;
  localparam int unsigned IN_W = ((NCH_MAX * SMP_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((IDX_W + 2 * SMP_W - 1 + 7) / 8) * 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES = 30;
  localparam int RAND_ITEMS = 550;
  localparam int QUIET_ITEMS = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [NCH_MAX-1:0][SMP_W-1:0] frame_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SMP_W-1:0] lo;
    logic [SMP_W-2:0] hi;
    logic             fin;
  } bucket_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    frame_t      smp;
    bit          last;
    bit          typed;
    bucket_t     res;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tlast;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [31:0]      cfg_data_i;

  // Shadow registers and track state of the decimator
  logic [3:0]       cfg_nch;
  logic [31:0]      cfg_spp;
  logic [IDX_W-1:0] cfg_npts;
  longint           st_frames;
  logic [IDX_W-1:0] st_buckets;
  longint           st_lo;
  longint           st_hi;

  bucket_t bucket_q[$];
  bucket_t got_bkt;
  bucket_t exp_bkt;
  int      errors;
  int      cycles;
  int      rx_hold;
  int      tx_pct;
  int      rx_pct;
  bit      no_gaps;
  bit      s_hi;

  waveform_min_max_overview u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void restart_track();
    st_frames = 0;
    st_buckets = '0;
    st_lo = 0;
    st_hi = 0;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      wmo_pkg::CFG_NUM_CHANNELS:      cfg_nch = val[3:0];
      wmo_pkg::CFG_SAMPLES_PER_POINT: cfg_spp = val;
      wmo_pkg::CFG_NUM_POINTS:        cfg_npts = val[IDX_W-1:0];
      default: ;
    endcase
  endfunction

  // Average one frame into the open bucket; return 1 when the bucket closes
  function automatic bit decimate_frame(input frame_t f, input bit last,
                                        output bucket_t b);
    int     nch;
    longint spp;
    longint sum;
    longint avg;
    b = '0;
    // Drop frames past the bucket limit, a last frame still ends the track
    if (st_buckets >= cfg_npts) begin
      if (last) restart_track();
      return 1'b0;
    end
    nch = (cfg_nch == 0) ? 1 : (cfg_nch > NCH_MAX) ? NCH_MAX : int'(cfg_nch);
    spp = (cfg_spp == 0) ? 1 : longint'(cfg_spp);
    sum = 0;
    for (int c = 0; c < nch; c++) sum += longint'($signed(f[c]));
    avg = sum / nch;
    if (avg < st_lo) st_lo = avg;
    if (avg > st_hi) st_hi = avg;
    if (!last && st_frames + 1 < spp) begin
      st_frames++;
      return 1'b0;
    end
    b.idx = st_buckets;
    b.lo = st_lo[SMP_W-1:0];
    b.hi = st_hi[SMP_W-2:0];
    b.fin = last || (st_buckets + 1 == cfg_npts);
    if (last) begin
      restart_track();
    end else begin
      st_buckets = st_buckets + 1'b1;
      st_frames = 0;
      st_lo = 0;
      st_hi = 0;
    end
    return 1'b1;
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'($urandom_range(0, 31)) - 24'd16;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    // Mostly independent channels, sometimes all pinned at one rail
    case ($urandom_range(0, 9))
      0: f = {NCH_MAX{24'h7FFFFF}};
      1: f = {NCH_MAX{24'h800000}};
      default: foreach (f[c]) f[c] = rand_sample();
    endcase
    return f;
  endfunction

  function automatic int pick_gap();
    if (no_gaps || $urandom_range(0, 99) >= tx_pct) return 0;
    return $urandom_range(1, 7);
  endfunction

  function automatic logic [31:0] pick_nch();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      7: v[3:0] = 4'd0;
      8: v[3:0] = 4'($urandom_range(9, 15));
      9: v[3:0] = 4'd8;
      default: v[3:0] = 4'($urandom_range(1, 8));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_spp();
    case ($urandom_range(0, 9))
      6: return 32'd0;
      7: return 32'hFFFF_FFFF;
      8: return $urandom();
      9: return $urandom_range(7, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [31:0] pick_npts();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      6: v[IDX_W-1:0] = '0;
      7: v[IDX_W-1:0] = '1;
      8: v[IDX_W-1:0] = 20'd1024;
      9: v[IDX_W-1:0] = 20'($urandom_range(13, 100));
      default: v[IDX_W-1:0] = 20'($urandom_range(1, 12));
    endcase
    return v;
  endfunction

  function automatic stim_row_t mk_frame(input logic [SMP_W-1:0] c0,
                                         input logic [SMP_W-1:0] crest, input bit last);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    foreach (r.smp[c]) r.smp[c] = (c == 0) ? c0 : crest;
    r.last = last;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t r;
    r = mk_frame('0, '0, 1'b0);
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t mk_rand(input bit last);
    stim_row_t r;
    r = mk_frame('0, '0, last);
    r.smp = rand_frame();
    return r;
  endfunction

  function automatic stim_row_t mk_typed(input logic [SMP_W-1:0] c0,
                                         input logic [SMP_W-1:0] crest, input bit last,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [SMP_W-1:0] lo,
                                         input logic [SMP_W-2:0] hi, input bit fin);
    stim_row_t r;
    r = mk_frame(c0, crest, last);
    r.typed = 1'b1;
    r.res.idx = idx;
    r.res.lo = lo;
    r.res.hi = hi;
    r.res.fin = fin;
    return r;
  endfunction

  // Drop valid once and hold it low for the gap given by n
  task automatic frame_idle(input int n);
    if (n > 0) begin
      if (s_hi) begin
        s_axis_tvalid <= 1'b0;
        s_hi = 1'b0;
      end
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold the sender until all buckets are out and the pipeline has settled
  task automatic wait_idle();
    if (s_hi) begin
      s_axis_tvalid <= 1'b0;
      s_hi = 1'b0;
    end
    while (bucket_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    apply_reg(idx, val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Predict the frame, then present it until it is taken
  task automatic send_frame(input frame_t smp, input bit last, input bit typed,
                            input bucket_t typed_res);
    bucket_t b;
    bit      hit;
    hit = decimate_frame(smp, last, b);
    if (hit) bucket_q.push_back(typed ? typed_res : b);
    s_axis_tdata <= smp;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    s_hi = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Check each bucket taken and apply receiver stall bursts
  always @(posedge clk_i) begin : rx_side
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_bkt.idx = m_axis_tdata[IDX_W-1:0];
      got_bkt.lo = m_axis_tdata[IDX_W +: SMP_W];
      got_bkt.hi = m_axis_tdata[IDX_W+SMP_W +: SMP_W-1];
      got_bkt.fin = m_axis_tlast;
      if (bucket_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected bucket: expected none, got index %0d", $time, got_bkt.idx);
      end else begin
        exp_bkt = bucket_q.pop_front();
        if (got_bkt.idx !== exp_bkt.idx) begin
          errors++;
          $display("%0t: bucket_index: expected %0d, got %0d", $time, exp_bkt.idx,
                   got_bkt.idx);
        end
        if (got_bkt.lo !== exp_bkt.lo) begin
          errors++;
          $display("%0t: bucket_min: expected %0d, got %0d", $time, $signed(exp_bkt.lo),
                   $signed(got_bkt.lo));
        end
        if (got_bkt.hi !== exp_bkt.hi) begin
          errors++;
          $display("%0t: bucket_max: expected %0d, got %0d", $time, exp_bkt.hi, got_bkt.hi);
        end
        if (got_bkt.fin !== exp_bkt.fin) begin
          errors++;
          $display("%0t: final_bucket: expected %0b, got %0b", $time, exp_bkt.fin,
                   got_bkt.fin);
        end
      end
    end
    if (rx_hold > 0) rx_hold--;
    else if (!no_gaps && $urandom_range(0, 99) < rx_pct) rx_hold = $urandom_range(1, 7);
    m_axis_tready <= (rx_hold == 0);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("waveform_min_max_overview test failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t dir_q[$];
    int        active;
    int        len;
    bit        clean_end;
    bit        last;
    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    errors = 0;
    cycles = 0;
    rx_hold = 0;
    tx_pct = 20;
    rx_pct = 20;
    no_gaps = 1'b0;
    s_hi = 1'b0;
    active = 0;
    cfg_nch = wmo_pkg::NCH_RESET;
    cfg_spp = wmo_pkg::SPP_RESET;
    cfg_npts = wmo_pkg::NPTS_RESET;
    restart_track();

    // Rails and rounding with reset settings: two channels, one frame per bucket
    dir_q.push_back(mk_typed(24'h7FFFFF, 24'h7FFFFF, 1'b0, 20'd0, 24'h000000, 23'h7FFFFF, 1'b0));
    dir_q.push_back(mk_typed(24'h800000, 24'h800000, 1'b0, 20'd1, 24'h800000, 23'h0, 1'b0));
    dir_q.push_back(mk_typed(24'h7FFFFF, 24'h800000, 1'b0, 20'd2, 24'h000000, 23'h0, 1'b0));
    dir_q.push_back(mk_typed(24'hFFFFFD, 24'h000000, 1'b0, 20'd3, 24'hFFFFFF, 23'h0, 1'b0));
    dir_q.push_back(mk_typed(24'h000005, 24'h000000, 1'b1, 20'd4, 24'h000000, 23'h2, 1'b1));
    // Zero channels act as one, writes to the spare index do nothing
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_CHANNELS, 32'h0));
    dir_q.push_back(mk_cfg(CFG_UNUSED, 32'hFFFF_FFFF));
    dir_q.push_back(mk_typed(24'h800000, 24'h7FFFFF, 1'b0, 20'd0, 24'h800000, 23'h0, 1'b0));
    // Channel count saturates at eight
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_CHANNELS, 32'hFFFF_FFFF));
    dir_q.push_back(mk_typed(24'h7FFFFF, 24'h7FFFFF, 1'b0, 20'd1, 24'h000000, 23'h7FFFFF, 1'b0));
    // Zero frames per bucket act as one
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_CHANNELS, 32'd8));
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_SAMPLES_PER_POINT, 32'd0));
    dir_q.push_back(mk_rand(1'b0));
    dir_q.push_back(mk_typed(24'h800000, 24'h800000, 1'b1, 20'd3, 24'h800000, 23'h0, 1'b1));
    // Two buckets of three, then the limit drops frames until a last frame
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_SAMPLES_PER_POINT, 32'd3));
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_POINTS, 32'd2));
    repeat (7) dir_q.push_back(mk_rand(1'b0));
    dir_q.push_back(mk_rand(1'b1));
    // No buckets allowed: every frame is dropped
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_POINTS, 32'd0));
    dir_q.push_back(mk_rand(1'b0));
    dir_q.push_back(mk_rand(1'b1));
    // Largest limits, one channel, bucket closed only by the last frame
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_POINTS, 32'h000F_FFFF));
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_SAMPLES_PER_POINT, 32'hFFFF_FFFF));
    dir_q.push_back(mk_cfg(wmo_pkg::CFG_NUM_CHANNELS, 32'd1));
    dir_q.push_back(mk_rand(1'b0));
    dir_q.push_back(mk_rand(1'b0));
    dir_q.push_back(mk_rand(1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_q[i].reg_idx, dir_q[i].reg_val);
      end else begin
        send_frame(dir_q[i].smp, dir_q[i].last, dir_q[i].typed, dir_q[i].res);
        frame_idle(pick_gap());
      end
    end

    // Random tracks, each under fresh settings written while idle
    while (active < RAND_ITEMS) begin
      no_gaps = (active >= RAND_ITEMS - QUIET_ITEMS);
      tx_pct = 20 * $urandom_range(0, 3);
      rx_pct = 20 * $urandom_range(0, 3);
      wait_idle();
      cfg_write(wmo_pkg::CFG_NUM_CHANNELS, pick_nch());
      cfg_write(wmo_pkg::CFG_SAMPLES_PER_POINT, pick_spp());
      cfg_write(wmo_pkg::CFG_NUM_POINTS, pick_npts());
      if ($urandom_range(0, 9) == 0) cfg_write(CFG_UNUSED, $urandom());
      len = $urandom_range(1, 30);
      clean_end = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < len; i++) begin
        last = (i == len - 1) ? clean_end : ($urandom_range(0, 24) == 0);
        send_frame(rand_frame(), last, 1'b0, '0);
        active++;
        frame_idle(pick_gap());
      end
    end

    // Drain and report
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("waveform_min_max_overview test passed");
    end else begin
      $display("waveform_min_max_overview test failed");
    end
    $finish;
  end

endmodule
